@@ rtl/core/set_pkg.sv @@
// Shared types, widths and constants for the seedling establishment tracker.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package set_pkg;

	localparam int NUM_LAYERS   = 8;
	localparam int MAX_LAYERS_D = 8;
	localparam int MOIST_W      = 16;
	localparam int TEMP_W       = 16;
	localparam int DAY_W        = 9;
	localparam int CNT_W        = 9;
	localparam int LCNT_W       = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int IN_TDATA_W   = 160;
	localparam int OUT_TDATA_W  = 16;
	localparam int TUSER_W      = 1;
	localparam int LAYER0_LSB   = DAY_W + TEMP_W;

	localparam logic [CNT_W-1:0]      CNT_MAX         = '1;
	localparam logic [17:0]           DAY_WINDOW_RST  = 18'd187392;
	localparam logic [LCNT_W-1:0]     LAYER_COUNT_RST = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GERM_MOIST_MIN  = 3'd0,
		CFG_ESTAB_MOIST_MIN = 3'd1,
		CFG_GERM_DAY_WIN    = 3'd2,
		CFG_GERM_TEMP_WIN   = 3'd3,
		CFG_ESTAB_TEMP_WIN  = 3'd4,
		CFG_WET_DRY_LIMITS  = 3'd5,
		CFG_GERM_ESTAB_DAYS = 3'd6,
		CFG_LAYER_COUNT     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [MOIST_W-1:0]       germ_moist_min;
		logic [DAY_W-1:0]         first_day;
		logic [DAY_W-1:0]         last_day;
		logic signed [TEMP_W-1:0] gt_min;
		logic signed [TEMP_W-1:0] gt_max;
		logic signed [TEMP_W-1:0] et_min;
		logic signed [TEMP_W-1:0] et_max;
		logic [CNT_W-1:0]         need_germ_wet;
		logic [CNT_W-1:0]         max_dry;
		logic [CNT_W-1:0]         need_estab_wet;
		logic [CNT_W-1:0]         min_days;
		logic [CNT_W-1:0]         max_days;
	} cfg_t;

	typedef struct packed {
		logic                     new_season;
		logic [DAY_W-1:0]         doy;
		logic signed [TEMP_W-1:0] temp;
		logic [MOIST_W-1:0]       m0;
	} day_t;

	typedef struct packed {
		logic             estab_failed;
		logic             estab_event;
		logic             season_closed;
		logic             germinated;
		logic [DAY_W-1:0] estab_day;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/set_cfg_regs.sv @@
// Configuration register file: write decode, reset values, field split,
// clamped layer count and the moisture threshold scaled by the layer count. Uses set_pkg.
`default_nettype none

module set_cfg_regs #(
	parameter int MAX_LAYERS = set_pkg::MAX_LAYERS_D,
	parameter int SUM_W      = set_pkg::MOIST_W + $clog2(MAX_LAYERS + 1)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [set_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [set_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output set_pkg::cfg_t                             cfg,
	output logic [set_pkg::LCNT_W-1:0]                layer_cnt,
	output logic [SUM_W-1:0]                          estab_thr_q
);

	logic [15:0] germ_moist_q;
	logic [15:0] estab_moist_q;
	logic [17:0] day_win_q;
	logic [31:0] gtemp_q;
	logic [31:0] etemp_q;
	logic [26:0] wet_dry_q;
	logic [17:0] g2e_q;
	logic [set_pkg::LCNT_W-1:0] lcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			germ_moist_q  <= '0;
			estab_moist_q <= '0;
			day_win_q     <= set_pkg::DAY_WINDOW_RST;
			gtemp_q       <= '0;
			etemp_q       <= '0;
			wet_dry_q     <= '0;
			g2e_q         <= '0;
			lcnt_q        <= set_pkg::LAYER_COUNT_RST;
		end else if (cfg_we) begin
			unique case (set_pkg::cfg_idx_t'(cfg_index))
				set_pkg::CFG_GERM_MOIST_MIN:  germ_moist_q  <= cfg_wdata[15:0];
				set_pkg::CFG_ESTAB_MOIST_MIN: estab_moist_q <= cfg_wdata[15:0];
				set_pkg::CFG_GERM_DAY_WIN:    day_win_q     <= cfg_wdata[17:0];
				set_pkg::CFG_GERM_TEMP_WIN:   gtemp_q       <= cfg_wdata[31:0];
				set_pkg::CFG_ESTAB_TEMP_WIN:  etemp_q       <= cfg_wdata[31:0];
				set_pkg::CFG_WET_DRY_LIMITS:  wet_dry_q     <= cfg_wdata[26:0];
				set_pkg::CFG_GERM_ESTAB_DAYS: g2e_q         <= cfg_wdata[17:0];
				set_pkg::CFG_LAYER_COUNT:     lcnt_q        <= cfg_wdata[3:0];
			endcase
		end
	end

	always_comb begin
		cfg.germ_moist_min = germ_moist_q;
		cfg.first_day      = day_win_q[8:0];
		cfg.last_day       = day_win_q[17:9];
		cfg.gt_min         = $signed(gtemp_q[15:0]);
		cfg.gt_max         = $signed(gtemp_q[31:16]);
		cfg.et_min         = $signed(etemp_q[15:0]);
		cfg.et_max         = $signed(etemp_q[31:16]);
		cfg.need_germ_wet  = wet_dry_q[8:0];
		cfg.max_dry        = wet_dry_q[17:9];
		cfg.need_estab_wet = wet_dry_q[26:18];
		cfg.min_days       = g2e_q[8:0];
		cfg.max_days       = g2e_q[17:9];
	end

	always_comb begin
		if (lcnt_q == '0)
			layer_cnt = set_pkg::LCNT_W'(1);
		else if (lcnt_q > set_pkg::LCNT_W'(MAX_LAYERS))
			layer_cnt = set_pkg::LCNT_W'(MAX_LAYERS);
		else
			layer_cnt = lcnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			estab_thr_q <= '0;
		else
			estab_thr_q <= SUM_W'(SUM_W'(estab_moist_q) * SUM_W'(layer_cnt));
	end

endmodule

`default_nettype wire

@@ rtl/core/set_day_ingest.sv @@
// Input register stage: unpacks one day request, sums the averaged layers
// and holds the day until the tracker takes it. Uses set_pkg.
`default_nettype none

module set_day_ingest #(
	parameter int MAX_LAYERS = set_pkg::MAX_LAYERS_D,
	parameter int SUM_W      = set_pkg::MOIST_W + $clog2(MAX_LAYERS + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [set_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  wire logic [set_pkg::TUSER_W-1:0]       s_tuser,
	input  wire logic [set_pkg::LCNT_W-1:0]        layer_cnt,
	input  wire logic                              take,
	output logic                                   valid_s1,
	output set_pkg::day_t                          day_s1,
	output logic [SUM_W-1:0]                       sum_s1
);

	set_pkg::day_t    day_d;
	logic [SUM_W-1:0] sum_d;
	logic             accept;

	assign s_tready = !valid_s1 || take;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		day_d.new_season = s_tuser[0];
		day_d.doy        = s_tdata[set_pkg::DAY_W-1:0];
		day_d.temp       = $signed(s_tdata[set_pkg::DAY_W +: set_pkg::TEMP_W]);
		day_d.m0         = s_tdata[set_pkg::LAYER0_LSB +: set_pkg::MOIST_W];
	end

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < MAX_LAYERS; i++) begin
			if (set_pkg::LCNT_W'(i) < layer_cnt)
				sum_d = sum_d + SUM_W'(
					s_tdata[set_pkg::LAYER0_LSB + i*set_pkg::MOIST_W +: set_pkg::MOIST_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			day_s1 <= day_d;
			sum_s1 <= sum_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/set_track_core.sv @@
// Tracking state and result register: germination and establishment
// update for one day per cycle while the result is not stalled. Uses set_pkg.
`default_nettype none

module set_track_core #(
	parameter int SUM_W = set_pkg::MOIST_W + 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire set_pkg::cfg_t                     cfg,
	input  wire logic [SUM_W-1:0]                  estab_thr,
	input  wire logic                              valid_s1,
	input  wire set_pkg::day_t                     day_s1,
	input  wire logic [SUM_W-1:0]                  sum_s1,
	output logic                                   take,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [set_pkg::OUT_TDATA_W-1:0]        m_tdata
);

	logic                              closed_q, germ_q;
	logic [set_pkg::DAY_W-1:0]         estab_day_q;
	logic [set_pkg::CNT_W-1:0]         dsg_q, dry_q, gwr_q, ewr_q;
	logic                              closed_c, germ_c;
	logic [set_pkg::DAY_W-1:0]         estab_day_c;
	logic [set_pkg::CNT_W-1:0]         dsg_c, dry_c, gwr_c, ewr_c;
	logic                              closed_n, germ_n;
	logic [set_pkg::DAY_W-1:0]         estab_day_n;
	logic [set_pkg::CNT_W-1:0]         dsg_n, dry_n, gwr_n, ewr_n;
	logic                              event_n, failed_n;
	set_pkg::res_t                     res_q;

	assign take     = valid_s1 && (!m_tvalid || m_tready);
	assign m_tdata  = set_pkg::OUT_TDATA_W'(res_q);

	always_comb begin
		closed_c    = closed_q;
		germ_c      = germ_q;
		estab_day_c = estab_day_q;
		dsg_c       = dsg_q;
		dry_c       = dry_q;
		gwr_c       = gwr_q;
		ewr_c       = ewr_q;
		if (day_s1.new_season) begin
			closed_c    = 1'b0;
			germ_c      = 1'b0;
			estab_day_c = '0;
			dsg_c       = '0;
			dry_c       = '0;
			gwr_c       = '0;
			ewr_c       = '0;
		end

		closed_n    = closed_c;
		germ_n      = germ_c;
		estab_day_n = estab_day_c;
		dsg_n       = dsg_c;
		dry_n       = dry_c;
		gwr_n       = gwr_c;
		ewr_n       = ewr_c;
		event_n     = 1'b0;
		failed_n    = 1'b0;

		if (!closed_c && estab_day_c == '0) begin
			gwr_n = (day_s1.m0 > cfg.germ_moist_min) ? set_pkg::sat_inc(gwr_c) : '0;
			if (day_s1.doy >= cfg.first_day) begin
				if (!germ_c) begin
					if (gwr_n >= cfg.need_germ_wet) begin
						if (day_s1.doy > cfg.last_day)
							closed_n = 1'b1;
						else if (day_s1.temp >= cfg.gt_min && day_s1.temp <= cfg.gt_max)
							germ_n = 1'b1;
					end
				end else begin
					if (sum_s1 < estab_thr) begin
						dry_n = set_pkg::sat_inc(dry_c);
						ewr_n = '0;
					end else begin
						dry_n = '0;
						ewr_n = set_pkg::sat_inc(ewr_c);
					end
					if (dry_n > cfg.max_dry || day_s1.temp < cfg.et_min
							|| day_s1.temp > cfg.et_max) begin
						failed_n = 1'b1;
					end else begin
						dsg_n = set_pkg::sat_inc(dsg_c);
						if (ewr_n >= cfg.need_estab_wet && dsg_n >= cfg.min_days) begin
							if (dsg_n > cfg.max_days) begin
								failed_n = 1'b1;
							end else begin
								estab_day_n = day_s1.doy;
								event_n     = 1'b1;
							end
						end
					end
					if (failed_n) begin
						ewr_n  = '0;
						dsg_n  = '0;
						germ_n = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q    <= 1'b0;
			germ_q      <= 1'b0;
			estab_day_q <= '0;
			dsg_q       <= '0;
			dry_q       <= '0;
			gwr_q       <= '0;
			ewr_q       <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			if (take) begin
				closed_q    <= closed_n;
				germ_q      <= germ_n;
				estab_day_q <= estab_day_n;
				dsg_q       <= dsg_n;
				dry_q       <= dry_n;
				gwr_q       <= gwr_n;
				ewr_q       <= ewr_n;
			end
			if (take)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.estab_day     <= estab_day_n;
			res_q.germinated    <= germ_n;
			res_q.season_closed <= closed_n;
			res_q.estab_event   <= event_n;
			res_q.estab_failed  <= failed_n;
		end
	end

	a_closed_germ_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(closed_q && germ_q))
		else $error("closed season with a live seedling");

	a_event_not_failed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.estab_event && res_q.estab_failed))
		else $error("establishment and failure on the same day");

	a_failed_clears_germ: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.estab_failed) |-> !res_q.germinated)
		else $error("failure left the seedling germinated");

	a_estab_day_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(estab_day_q != '0 && !(take && day_s1.new_season)) |=> $stable(estab_day_q))
		else $error("recorded establishment day changed within a season");

	a_event_sets_day: assert property (@(posedge clk) disable iff (!arst_n)
		(take && event_n) |=> (estab_day_q == $past(day_s1.doy)))
		else $error("establishment event did not record the day");

endmodule

`default_nettype wire

@@ rtl/core/seedling_establishment_tracker_core.sv @@
// Top level of the seedling establishment tracker: configuration registers,
// input stage and tracking core. Uses set_pkg, set_cfg_regs, set_day_ingest, set_track_core.
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+---------------------------------------
//  s_ day   | s_tvalid s_tready s_tdata s_tuser | one day: season flag, day, temp, layers
//  m_ res   | m_tvalid m_tready m_tdata        | day result after the update
//  cfg      | cfg_we cfg_index cfg_wdata       | register write, no read-back
//
// One day per cycle sustained while results are taken; a request passes the input
// register, which holds the layer sum, then the tracking state and result register,
// which update together when the tracker takes the day.
// Asynchronous reset clears all tracking state and loads register defaults.
// A stalled result holds the tracker; the input stage holds one waiting day.
`default_nettype none

module seedling_establishment_tracker_core #(
	parameter int MAX_LAYERS = set_pkg::MAX_LAYERS_D
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// day_of_year[8:0], avg_temp[24:9], moisture_layer0..7 [40:25]..[152:137], zero fill
	input  wire logic [set_pkg::IN_TDATA_W-1:0]       s_tdata,
	// new_season[0]
	input  wire logic [set_pkg::TUSER_W-1:0]          s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// estab_day[8:0], germinated[9], season_closed[10], estab_event[11],
	// estab_failed[12], zero fill
	output logic [set_pkg::OUT_TDATA_W-1:0]           m_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [set_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [set_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	localparam int SUM_W = set_pkg::MOIST_W + $clog2(MAX_LAYERS + 1);

	set_pkg::cfg_t               cfg;
	logic [set_pkg::LCNT_W-1:0]  layer_cnt;
	logic [SUM_W-1:0]            estab_thr;
	logic                        take;
	logic                        valid_s1;
	set_pkg::day_t               day_s1;
	logic [SUM_W-1:0]            sum_s1;

	set_cfg_regs #(
		.MAX_LAYERS (MAX_LAYERS),
		.SUM_W      (SUM_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.cfg         (cfg),
		.layer_cnt   (layer_cnt),
		.estab_thr_q (estab_thr)
	);

	set_day_ingest #(
		.MAX_LAYERS (MAX_LAYERS),
		.SUM_W      (SUM_W)
	) u_ingest (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.layer_cnt (layer_cnt),
		.take      (take),
		.valid_s1  (valid_s1),
		.day_s1    (day_s1),
		.sum_s1    (sum_s1)
	);

	set_track_core #(
		.SUM_W (SUM_W)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.estab_thr (estab_thr),
		.valid_s1  (valid_s1),
		.day_s1    (day_s1),
		.sum_s1    (sum_s1),
		.take      (take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
